>>> rtl/plist_pkg.sv
// Package for the positional list engine: sizes, op and status codes,
// memory write-port structs. No dependencies.
package plist_pkg;

  localparam int CAPACITY   = 64;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int OP_W       = 3;
  localparam int POS_W      = 7;
  localparam int VAL_W      = 32;
  localparam int ST_W       = 3;
  localparam int GROUP_W    = 8;
  localparam int NUM_GROUPS = CAPACITY / GROUP_W;
  localparam int GRP_W      = SLOT_W - $clog2(GROUP_W);
  localparam int LOC_W      = $clog2(GROUP_W);

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_RMHEAD = 3'd3;
  localparam logic [OP_W-1:0] OP_RMTAIL = 3'd4;
  localparam logic [OP_W-1:0] OP_READ   = 3'd5;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [ST_W-1:0] ST_BOUNDS   = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] wdata;
  } link_wr_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
  } val_wr_t;

endpackage

>>> rtl/plist_store.sv
// Slot storage: link memory and value memory, one write and one
// registered read per cycle each. Depends on plist_pkg.
module plist_store import plist_pkg::*; (
  input  logic              clk_i,
  input  link_wr_t          lk_wr_i,
  input  val_wr_t           val_wr_i,
  input  logic [SLOT_W-1:0] raddr_i,
  output logic [SLOT_W-1:0] link_o,
  output logic [VAL_W-1:0]  value_o
);

  logic [SLOT_W-1:0] link_mem [CAPACITY];
  logic [VAL_W-1:0]  val_mem  [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (lk_wr_i.we) begin
      link_mem[lk_wr_i.waddr] <= lk_wr_i.wdata;
    end
    link_o <= link_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (val_wr_i.we) begin
      val_mem[val_wr_i.waddr] <= val_wr_i.wdata;
    end
    value_o <= val_mem[raddr_i];
  end

endmodule

>>> rtl/plist_free.sv
// Lowest free slot finder: two-stage registered priority tree over the
// slot-used bits (group finds, then the slot, registered). Depends on plist_pkg.
module plist_free import plist_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CAPACITY-1:0] used_i,
  output logic [SLOT_W-1:0]   free_slot_o
);

  logic [NUM_GROUPS-1:0] any_d, any_q;
  logic [LOC_W-1:0]      loc_d [NUM_GROUPS];
  logic [LOC_W-1:0]      loc_q [NUM_GROUPS];
  logic [SLOT_W-1:0]     free_d, free_q;

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      any_d[g] = 1'b0;
      loc_d[g] = '0;
      for (int b = GROUP_W - 1; b >= 0; b--) begin
        if (!used_i[g*GROUP_W + b]) begin
          any_d[g] = 1'b1;
          loc_d[g] = LOC_W'(b);
        end
      end
    end
  end

  always_comb begin
    free_d = '0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (any_q[g]) begin
        free_d = {GRP_W'(g), loc_q[g]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q  <= '0;
      free_q <= '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        loc_q[g] <= '0;
      end
    end else begin
      any_q  <= any_d;
      free_q <= free_d;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        loc_q[g] <= loc_d[g];
      end
    end
  end

  assign free_slot_o = free_q;

endmodule

>>> rtl/positional_list_engine.sv
// Positional list engine top level: request sequencer, link walker and list
// state. Depends on plist_pkg, plist_store and plist_free.
//
// Usage: present op_i, position_i and value_i with start high; the item is
// taken at a rising edge where start is high and busy is low. busy stays
// high until the result is produced. Each item yields one result: status_o,
// read_value_o and length_o, valid for exactly one cycle while done_o is
// high. The receiver cannot stall; results must be taken when shown.
// Sequence: a request rejected up front (full, empty, out of bounds, not
// found, unused op) shows its result in the cycle after acceptance. Append
// and insert at the head pass setup and a first step, append to a non-empty
// list also a second step. Positional requests and remove tail walk the link
// chain one slot per cycle through the link memory read port, then step.
// A new item may be accepted in the cycle its predecessor's result shows.
// Reset clears the list (all slots free, length zero); slot memories are
// not cleared and need no clearing pass.
module positional_list_engine import plist_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [OP_W-1:0]         op_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    done_o,
  output logic [ST_W-1:0]         status_o,
  output logic signed [VAL_W-1:0] read_value_o,
  output logic [CNT_W-1:0]        length_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_STEP1 = 3'd3;
  localparam logic [2:0] S_STEP2 = 3'd4;

  localparam logic [2:0] A_APP   = 3'd0;
  localparam logic [2:0] A_INS0  = 3'd1;
  localparam logic [2:0] A_INS   = 3'd2;
  localparam logic [2:0] A_DHEAD = 3'd3;
  localparam logic [2:0] A_DTAIL = 3'd4;
  localparam logic [2:0] A_DMID  = 3'd5;
  localparam logic [2:0] A_READ  = 3'd6;

  logic [2:0]          state_d, state_q;
  logic [2:0]          act_d, act_q;
  logic [OP_W-1:0]     op_d, op_q;
  logic [POS_W-1:0]    pos_d, pos_q;
  logic [VAL_W-1:0]    val_d, val_q;
  logic [SLOT_W-1:0]   steps_d, steps_q;
  logic                first_d, first_q;
  logic [SLOT_W-1:0]   prev_d, prev_q;
  logic [SLOT_W-1:0]   slot_d, slot_q;
  logic [SLOT_W-1:0]   head_d, head_q;
  logic [SLOT_W-1:0]   tail_d, tail_q;
  logic [CNT_W-1:0]    count_d, count_q;
  logic [CAPACITY-1:0] used_d, used_q;
  logic                done_d, done_q;
  logic [ST_W-1:0]     status_d, status_q;
  logic [VAL_W-1:0]    rdval_d, rdval_q;
  logic [CNT_W-1:0]    length_d, length_q;

  link_wr_t            lk_wr;
  val_wr_t             val_wr;
  logic [SLOT_W-1:0]   raddr;
  logic [SLOT_W-1:0]   lk_rd;
  logic [VAL_W-1:0]    val_rd;
  logic [SLOT_W-1:0]   free_slot;
  logic [SLOT_W-1:0]   walk_cur;
  logic                fin;
  logic [VAL_W-1:0]    fin_rd;
  logic                go;
  logic [ST_W-1:0]     rej_st;

  plist_store u_store (
    .clk_i    (clk_i),
    .lk_wr_i  (lk_wr),
    .val_wr_i (val_wr),
    .raddr_i  (raddr),
    .link_o   (lk_rd),
    .value_o  (val_rd)
  );

  plist_free u_free (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .used_i      (used_q),
    .free_slot_o (free_slot)
  );

  assign walk_cur = first_q ? head_q : lk_rd;
  assign busy     = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    op_d     = op_q;
    pos_d    = pos_q;
    val_d    = val_q;
    steps_d  = steps_q;
    first_d  = first_q;
    prev_d   = prev_q;
    slot_d   = slot_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    used_d   = used_q;
    done_d   = 1'b0;
    status_d = status_q;
    rdval_d  = rdval_q;
    length_d = length_q;
    raddr    = walk_cur;
    lk_wr    = '0;
    val_wr   = '0;
    fin      = 1'b0;
    fin_rd   = '0;
    go       = 1'b0;
    rej_st   = ST_OK;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d  = op_i;
          pos_d = position_i;
          val_d = value_i;
          case (op_i) inside
            OP_APPEND: begin
              if (count_q == CNT_W'(CAPACITY)) rej_st = ST_FULL;
              else go = 1'b1;
            end
            OP_INSERT: begin
              if (position_i > count_q) rej_st = ST_BOUNDS;
              else if (count_q == CNT_W'(CAPACITY)) rej_st = ST_FULL;
              else go = 1'b1;
            end
            OP_DELETE: begin
              if (count_q == '0) rej_st = ST_EMPTY;
              else if (position_i >= count_q) rej_st = ST_BOUNDS;
              else go = 1'b1;
            end
            OP_RMHEAD, OP_RMTAIL: begin
              if (count_q == '0) rej_st = ST_EMPTY;
              else go = 1'b1;
            end
            OP_READ: begin
              if (position_i >= count_q) rej_st = ST_NOTFOUND;
              else go = 1'b1;
            end
            default: rej_st = ST_OK;
          endcase
          if (go) begin
            state_d = S_SETUP;
          end else begin
            done_d   = 1'b1;
            status_d = rej_st;
            rdval_d  = '0;
            length_d = count_q;
          end
        end
      end

      S_SETUP: begin
        first_d = 1'b1;
        steps_d = '0;
        state_d = S_WALK;
        case (op_q)
          OP_APPEND: begin
            act_d   = A_APP;
            state_d = S_STEP1;
          end
          OP_INSERT: begin
            if (pos_q == '0) begin
              act_d   = A_INS0;
              state_d = S_STEP1;
            end else begin
              act_d   = A_INS;
              steps_d = SLOT_W'(pos_q - POS_W'(1));
            end
          end
          OP_DELETE: begin
            if (pos_q == '0) begin
              act_d = A_DHEAD;
            end else if (POS_W'(pos_q) == POS_W'(count_q - CNT_W'(1))) begin
              act_d   = A_DTAIL;
              steps_d = SLOT_W'(count_q - CNT_W'(2));
            end else begin
              act_d   = A_DMID;
              steps_d = SLOT_W'(pos_q - POS_W'(1));
            end
          end
          OP_RMHEAD: act_d = A_DHEAD;
          OP_RMTAIL: begin
            if (count_q == CNT_W'(1)) begin
              act_d = A_DHEAD;
            end else begin
              act_d   = A_DTAIL;
              steps_d = SLOT_W'(count_q - CNT_W'(2));
            end
          end
          OP_READ: begin
            act_d   = A_READ;
            steps_d = SLOT_W'(pos_q);
          end
          default: fin = 1'b1;
        endcase
      end

      S_WALK: begin
        if (steps_q == '0) begin
          prev_d  = walk_cur;
          state_d = S_STEP1;
        end else begin
          steps_d = steps_q - SLOT_W'(1);
          first_d = 1'b0;
        end
      end

      S_STEP1: begin
        case (act_q)
          A_APP: begin
            slot_d            = free_slot;
            used_d[free_slot] = 1'b1;
            val_wr            = '{we: 1'b1, waddr: free_slot, wdata: val_q};
            lk_wr             = '{we: 1'b1, waddr: free_slot, wdata: '0};
            if (count_q == '0) begin
              head_d  = free_slot;
              tail_d  = free_slot;
              count_d = count_q + CNT_W'(1);
              fin     = 1'b1;
            end else begin
              state_d = S_STEP2;
            end
          end
          A_INS0: begin
            used_d[free_slot] = 1'b1;
            val_wr            = '{we: 1'b1, waddr: free_slot, wdata: val_q};
            lk_wr             = '{we: 1'b1, waddr: free_slot, wdata: head_q};
            head_d            = free_slot;
            if (count_q == '0) tail_d = free_slot;
            count_d = count_q + CNT_W'(1);
            fin     = 1'b1;
          end
          A_INS: begin
            slot_d            = free_slot;
            used_d[free_slot] = 1'b1;
            val_wr            = '{we: 1'b1, waddr: free_slot, wdata: val_q};
            lk_wr             = '{we: 1'b1, waddr: free_slot, wdata: lk_rd};
            state_d           = S_STEP2;
          end
          A_DHEAD: begin
            used_d[head_q] = 1'b0;
            count_d        = count_q - CNT_W'(1);
            if (count_q == CNT_W'(1)) begin
              head_d = '0;
              tail_d = '0;
            end else begin
              head_d = lk_rd;
            end
            fin = 1'b1;
          end
          A_DTAIL: begin
            used_d[tail_q] = 1'b0;
            tail_d         = prev_q;
            count_d        = count_q - CNT_W'(1);
            fin            = 1'b1;
          end
          A_DMID: begin
            slot_d  = lk_rd;
            raddr   = lk_rd;
            state_d = S_STEP2;
          end
          A_READ: begin
            fin_rd = val_rd;
            fin    = 1'b1;
          end
          default: fin = 1'b1;
        endcase
      end

      S_STEP2: begin
        case (act_q)
          A_APP: begin
            lk_wr   = '{we: 1'b1, waddr: tail_q, wdata: slot_q};
            tail_d  = slot_q;
            count_d = count_q + CNT_W'(1);
          end
          A_INS: begin
            lk_wr = '{we: 1'b1, waddr: prev_q, wdata: slot_q};
            if (pos_q == count_q) tail_d = slot_q;
            count_d = count_q + CNT_W'(1);
          end
          A_DMID: begin
            lk_wr          = '{we: 1'b1, waddr: prev_q, wdata: lk_rd};
            used_d[slot_q] = 1'b0;
            count_d        = count_q - CNT_W'(1);
          end
          default: count_d = count_q;
        endcase
        fin = 1'b1;
      end

      default: state_d = S_IDLE;
    endcase

    if (fin) begin
      state_d  = S_IDLE;
      done_d   = 1'b1;
      status_d = ST_OK;
      rdval_d  = fin_rd;
      length_d = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      act_q    <= A_APP;
      op_q     <= '0;
      pos_q    <= '0;
      val_q    <= '0;
      steps_q  <= '0;
      first_q  <= 1'b0;
      prev_q   <= '0;
      slot_q   <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      used_q   <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      rdval_q  <= '0;
      length_q <= '0;
    end else begin
      state_q  <= state_d;
      act_q    <= act_d;
      op_q     <= op_d;
      pos_q    <= pos_d;
      val_q    <= val_d;
      steps_q  <= steps_d;
      first_q  <= first_d;
      prev_q   <= prev_d;
      slot_q   <= slot_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      used_q   <= used_d;
      done_q   <= done_d;
      status_q <= status_d;
      rdval_q  <= rdval_d;
      length_q <= length_d;
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign read_value_o = rdval_q;
  assign length_o     = length_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_used_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> ($countones(used_q) == int'(count_q)))
    else $error("used slots disagree with element count");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted item neither in progress nor answered");

  a_length_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (length_o == count_q))
    else $error("reported length differs from list length");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == '0 && tail_q == '0))
    else $error("empty list with nonzero head or tail");

endmodule
